// ===== src/unvisited_neighbour_enumerator_core_assert.svh =====
// Assertion macros for the unvisited neighbour enumerator.
// Used by files that include this header; relies on clk and arst_n in the including module.
`ifndef UNVISITED_NEIGHBOUR_ENUMERATOR_CORE_ASSERT_SVH
`define UNVISITED_NEIGHBOUR_ENUMERATOR_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset.
`define UNE_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("une assertion failed");
// Next-cycle implication, checked outside reset.
`define UNE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("une assertion failed");
`else
`define UNE_ASSERT_IMPL(label, ante, cons)
`define UNE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== src/une_pkg.sv =====
// Shared types and constants of the unvisited neighbour enumerator.
// No dependencies; used by unvisited_neighbour_enumerator_core.
package une_pkg;

	localparam int UNE_AXIS_MAX = 32;
	localparam int COORD_W      = 5;
	localparam int SIZE_W       = 6;
	localparam int CFG_IDX_W    = 3;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FLAT_MODE = 3'd3;

	// Command codes.
	localparam logic FUNC_QUERY = 1'b0;
	localparam logic FUNC_CLEAR = 1'b1;

	// Offset counter codes: step -1, 0, +1 along one axis.
	localparam logic [1:0] OFF_LO  = 2'd0;
	localparam logic [1:0] OFF_MID = 2'd1;
	localparam logic [1:0] OFF_HI  = 2'd2;

	typedef struct packed {
		logic               func;
		logic [COORD_W-1:0] cell_x;
		logic [COORD_W-1:0] cell_y;
		logic [COORD_W-1:0] cell_z;
	} une_in_t;

	typedef struct packed {
		logic [COORD_W-1:0] nb_x;
		logic [COORD_W-1:0] nb_y;
		logic [COORD_W-1:0] nb_z;
		logic               empty_res;
		logic               last;
	} une_out_t;

endpackage

// ===== src/unvisited_neighbour_enumerator_core.sv =====
// Unvisited neighbour enumerator: visited-mark store, one-hot sequencer and output register.
// Depends on une_pkg and unvisited_neighbour_enumerator_core_assert.svh.
// Query: the own row and 9 neighbour rows are read and 27 scan steps run; one command is
// taken at a time, as in_ready is high only in the idle state.
// Clear: one row of z marks written per cycle, then an empty result with last set.
// Reset: registers go to their reset values, then a sweep over all AXIS^2 rows zeroes the store
// while in_ready stays low; configuration writes are taken throughout.
`include "unvisited_neighbour_enumerator_core_assert.svh"

module unvisited_neighbour_enumerator_core #(
	parameter int AXIS_MAX = une_pkg::UNE_AXIS_MAX
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  une_pkg::une_in_t                    in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output une_pkg::une_out_t                   out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [une_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [une_pkg::SIZE_W-1:0]          cfg_data
);
	import une_pkg::*;

	// Axes never exceed 32 cells, whatever AXIS_MAX says.
	localparam int AXIS_EFF = (AXIS_MAX < 32) ? AXIS_MAX : 32;
	localparam int CW       = $clog2(AXIS_EFF);
	localparam int ROWS     = AXIS_EFF * AXIS_EFF;
	localparam int ROW_W    = $clog2(ROWS);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_CLEAR = 7'b0000010,
		S_CHECK = 7'b0000100,
		S_OWN   = 7'b0001000,
		S_SCAN  = 7'b0010000,
		S_FIN   = 7'b0100000,
		S_EMPTY = 7'b1000000
	} state_t;

	typedef struct packed {
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic [CW-1:0] z;
	} cell_t;

	state_t state_q, state_d;
	logic   boot_q, boot_d;
	logic [ROW_W-1:0] sweep_q, sweep_d;
	une_in_t cmd_q;
	logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
	logic flat_q;
	logic [1:0] ix_q, iy_q, iz_q, ix_d, iy_d, iz_d;
	logic  pend_v_q, pend_v_d;
	cell_t pend_q, pend_d;
	logic  out_valid_q;
	une_out_t out_q, out_d;
	logic  out_load, out_free;

	// Store: one row per (x, y), one bit per z.
	logic [AXIS_EFF-1:0] marks [ROWS];
	logic [AXIS_EFF-1:0] rdata_q;
	logic                rd_en, wr_en;
	logic [ROW_W-1:0]    rd_addr, wr_addr;
	logic [AXIS_EFF-1:0] wdata;

	logic [SIZE_W-1:0] nx, ny, nz;
	logic [SIZE_W-1:0] qx, qy, qz;
	logic oob, halo;
	logic [CW-1:0] cx, cy, cz;
	logic [AXIS_EFF-1:0] cz_bit;
	logic [1:0] rx_i, ry_i;
	logic [CW-1:0] rx, ry;
	logic [CW-1:0] px, py, pz;
	logic z_ok, center, cand, last_pair;
	logic [ROW_W-1:0] own_addr;

	assign nx = (size_x_q > SIZE_W'(AXIS_EFF)) ? SIZE_W'(AXIS_EFF) : size_x_q;
	assign ny = (size_y_q > SIZE_W'(AXIS_EFF)) ? SIZE_W'(AXIS_EFF) : size_y_q;
	assign nz = (size_z_q > SIZE_W'(AXIS_EFF)) ? SIZE_W'(AXIS_EFF) : size_z_q;

	assign qx = SIZE_W'(cmd_q.cell_x);
	assign qy = SIZE_W'(cmd_q.cell_y);
	assign qz = SIZE_W'(cmd_q.cell_z);

	assign oob  = (qx >= nx) || (qy >= ny) || (qz >= nz);
	assign halo = (qx == '0) || (qx + SIZE_W'(1) == nx) ||
	              (qy == '0) || (qy + SIZE_W'(1) == ny) ||
	              (!flat_q && ((qz == '0) || (qz + SIZE_W'(1) == nz)));

	// Past the range check every index fits the narrowed coordinate width.
	assign cx = cmd_q.cell_x[CW-1:0];
	assign cy = cmd_q.cell_y[CW-1:0];
	assign cz = cmd_q.cell_z[CW-1:0];
	assign cz_bit = AXIS_EFF'(1) << cz;

	// A non-halo cell keeps its x and y neighbours in bounds; only z needs a check.
	assign px = cx + CW'(ix_q) - CW'(1);
	assign py = cy + CW'(iy_q) - CW'(1);
	assign pz = cz + CW'(iz_q) - CW'(1);
	assign z_ok = !((iz_q == OFF_LO) && (qz == '0)) &&
	              !((iz_q == OFF_HI) && (qz + SIZE_W'(1) == nz));
	assign center = (ix_q == OFF_MID) && (iy_q == OFF_MID) && (iz_q == OFF_MID);
	assign cand = z_ok && !center && !rdata_q[pz];
	assign last_pair = (ix_q == OFF_HI) && (iy_q == OFF_HI);

	assign rx = cx + CW'(rx_i) - CW'(1);
	assign ry = cy + CW'(ry_i) - CW'(1);
	assign rd_addr  = ROW_W'(ROW_W'(rx) * ROW_W'(AXIS_EFF) + ROW_W'(ry));
	assign own_addr = ROW_W'(ROW_W'(cx) * ROW_W'(AXIS_EFF) + ROW_W'(cy));

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		state_d  = state_q;
		boot_d   = boot_q;
		sweep_d  = sweep_q;
		ix_d     = ix_q;
		iy_d     = iy_q;
		iz_d     = iz_q;
		pend_v_d = pend_v_q;
		pend_d   = pend_q;
		out_load = 1'b0;
		out_d    = out_q;
		rd_en    = 1'b0;
		rx_i     = OFF_MID;
		ry_i     = OFF_MID;
		wr_en    = 1'b0;
		wr_addr  = own_addr;
		wdata    = rdata_q | cz_bit;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					sweep_d = '0;
					state_d = (in_data.func == FUNC_CLEAR) ? S_CLEAR : S_CHECK;
				end
			end
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = sweep_q;
				wdata   = '0;
				sweep_d = sweep_q + ROW_W'(1);
				if (sweep_q == ROW_W'(ROWS - 1)) begin
					boot_d  = 1'b0;
					state_d = boot_q ? S_IDLE : S_EMPTY;
				end
			end
			S_CHECK: begin
				if (oob || halo) begin
					state_d = S_EMPTY;
				end else begin
					rd_en   = 1'b1;
					state_d = S_OWN;
				end
			end
			S_OWN: begin
				if (rdata_q[cz]) begin
					state_d = S_EMPTY;
				end else begin
					// Mark the cell and fetch the first neighbour row in the same cycle.
					wr_en    = 1'b1;
					rd_en    = 1'b1;
					rx_i     = OFF_LO;
					ry_i     = OFF_LO;
					ix_d     = OFF_LO;
					iy_d     = OFF_LO;
					iz_d     = OFF_LO;
					pend_v_d = 1'b0;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				// One result is held back so that the final one can carry last.
				if (!(cand && pend_v_q && !out_free)) begin
					if (cand) begin
						if (pend_v_q) begin
							out_load        = 1'b1;
							out_d.nb_x      = COORD_W'(pend_q.x);
							out_d.nb_y      = COORD_W'(pend_q.y);
							out_d.nb_z      = COORD_W'(pend_q.z);
							out_d.empty_res = 1'b0;
							out_d.last      = 1'b0;
						end
						pend_v_d = 1'b1;
						pend_d   = '{x: px, y: py, z: pz};
					end
					if (iz_q == OFF_HI) begin
						iz_d = OFF_LO;
						if (last_pair) begin
							state_d = S_FIN;
						end else begin
							if (iy_q == OFF_HI) begin
								ix_d = ix_q + 2'd1;
								iy_d = OFF_LO;
							end else begin
								iy_d = iy_q + 2'd1;
							end
							rd_en = 1'b1;
							rx_i  = ix_d;
							ry_i  = iy_d;
						end
					end else begin
						iz_d = iz_q + 2'd1;
					end
				end
			end
			S_FIN: begin
				if (out_free) begin
					out_load        = 1'b1;
					out_d.nb_x      = pend_v_q ? COORD_W'(pend_q.x) : '0;
					out_d.nb_y      = pend_v_q ? COORD_W'(pend_q.y) : '0;
					out_d.nb_z      = pend_v_q ? COORD_W'(pend_q.z) : '0;
					out_d.empty_res = !pend_v_q;
					out_d.last      = 1'b1;
					state_d         = S_IDLE;
				end
			end
			S_EMPTY: begin
				if (out_free) begin
					out_load        = 1'b1;
					out_d.nb_x      = '0;
					out_d.nb_y      = '0;
					out_d.nb_z      = '0;
					out_d.empty_res = 1'b1;
					out_d.last      = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			boot_q      <= 1'b1;
			sweep_q     <= '0;
			ix_q        <= OFF_LO;
			iy_q        <= OFF_LO;
			iz_q        <= OFF_LO;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
			size_x_q    <= SIZE_W'(3);
			size_y_q    <= SIZE_W'(3);
			size_z_q    <= SIZE_W'(1);
			flat_q      <= 1'b1;
		end else begin
			state_q  <= state_d;
			boot_q   <= boot_d;
			sweep_q  <= sweep_d;
			ix_q     <= ix_d;
			iy_q     <= iy_d;
			iz_q     <= iz_d;
			pend_v_q <= pend_v_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				case (cfg_index)
					REG_SIZE_X:    size_x_q <= cfg_data;
					REG_SIZE_Y:    size_y_q <= cfg_data;
					REG_SIZE_Z:    size_z_q <= cfg_data;
					REG_FLAT_MODE: flat_q   <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q <= in_data;
		end
		pend_q <= pend_d;
		if (out_load) begin
			out_q <= out_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			marks[wr_addr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= marks[rd_addr];
		end
	end

	`UNE_ASSERT_IMPL(a_empty_is_last, out_valid && out_data.empty_res, out_data.last)
	`UNE_ASSERT_IMPL(a_load_when_free, out_load, out_free)
	`UNE_ASSERT_IMPL(a_write_states, wr_en, (state_q == S_OWN) || (state_q == S_CLEAR))
	`UNE_ASSERT_NEXT(a_no_self_listing, (state_q == S_SCAN) && cand && !pend_v_q, pend_v_q && !((pend_q.x == cx) && (pend_q.y == cy) && (pend_q.z == cz)))

endmodule

// ===== test/tb_unvisited_neighbour_enumerator_core.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for unvisited_neighbour_enumerator_core: grid queries, clears and
// register writes against an in-bench prediction of the visited marks and neighbour lists.
// Depends on une_pkg and the core RTL.
module tb_unvisited_neighbour_enumerator_core;
	import une_pkg::*;

	localparam int HOLD_CYCLES    = 250;
	localparam int WATCHDOG_LIMIT = 6000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int MARK_COUNT     = UNE_AXIS_MAX * UNE_AXIS_MAX * UNE_AXIS_MAX;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	une_in_t              in_data;
	logic                 out_valid;
	logic                 out_ready;
	une_out_t             out_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SIZE_W-1:0]    cfg_data;

	// Predicted register contents and visited marks.
	logic [SIZE_W-1:0] grid_x = 6'd3;
	logic [SIZE_W-1:0] grid_y = 6'd3;
	logic [SIZE_W-1:0] grid_z = 6'd1;
	logic              grid_flat = 1'b1;
	bit                marks [MARK_COUNT];

	une_out_t awaited_neighbours [$];
	int       fail_count = 0;
	int       quiet_cycles = 0;
	bit       idle_on = 1'b1;
	bit       hold_request = 1'b0;
	int       walk_x = 1;
	int       walk_y = 1;
	int       walk_z = 1;

	unvisited_neighbour_enumerator_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int axis_cells(logic [SIZE_W-1:0] reg_value);
		int s;
		s = int'(reg_value);
		if (s > UNE_AXIS_MAX) s = UNE_AXIS_MAX;
		if (s > 32) s = 32;
		return s;
	endfunction

	function automatic int mark_slot(int x, int y, int z);
		return (x * UNE_AXIS_MAX + y) * UNE_AXIS_MAX + z;
	endfunction

	function automatic bit on_rim(int v, int n);
		return v == 0 || v + 1 == n;
	endfunction

	function automatic int clamp(int v, int lo, int hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// Appends one predicted result transaction to the tail of the expectation queue.
	function automatic void queue_result(une_out_t res);
		awaited_neighbours = {awaited_neighbours, res};
	endfunction

	// Updates the marks for one accepted transaction and queues the neighbours it should list.
	function automatic void enumerate_unvisited(une_in_t item);
		int       nx, ny, nz, cx, cy, cz, px, py, pz;
		bit       give_empty, held;
		une_out_t entry, blank;
		nx = axis_cells(grid_x);
		ny = axis_cells(grid_y);
		nz = axis_cells(grid_z);
		cx = int'(item.cell_x);
		cy = int'(item.cell_y);
		cz = int'(item.cell_z);
		give_empty = 1'b0;
		held = 1'b0;
		entry = '0;
		if (item.func == FUNC_CLEAR) begin
			foreach (marks[i]) marks[i] = 1'b0;
			give_empty = 1'b1;
		end else if (cx >= nx || cy >= ny || cz >= nz) begin
			give_empty = 1'b1;
		end else if (on_rim(cx, nx) || on_rim(cy, ny) || (!grid_flat && on_rim(cz, nz))) begin
			give_empty = 1'b1;
		end else if (marks[mark_slot(cx, cy, cz)]) begin
			give_empty = 1'b1;
		end else begin
			marks[mark_slot(cx, cy, cz)] = 1'b1;
			for (int dx = -1; dx <= 1; dx++) begin
				for (int dy = -1; dy <= 1; dy++) begin
					for (int dz = -1; dz <= 1; dz++) begin
						px = cx + dx;
						py = cy + dy;
						pz = cz + dz;
						if (dx == 0 && dy == 0 && dz == 0) continue;
						if (px < 0 || py < 0 || pz < 0) continue;
						if (px >= nx || py >= ny || pz >= nz) continue;
						if (marks[mark_slot(px, py, pz)]) continue;
						// Hold each neighbour back one step so the final one can carry last.
						if (held) queue_result(entry);
						entry.nb_x = COORD_W'(px);
						entry.nb_y = COORD_W'(py);
						entry.nb_z = COORD_W'(pz);
						entry.empty_res = 1'b0;
						entry.last = 1'b0;
						held = 1'b1;
					end
				end
			end
			if (held) begin
				entry.last = 1'b1;
				queue_result(entry);
			end else begin
				give_empty = 1'b1;
			end
		end
		if (give_empty) begin
			blank = '0;
			blank.empty_res = 1'b1;
			blank.last = 1'b1;
			queue_result(blank);
		end
	endfunction

	function automatic une_in_t make_item(logic func, int x, int y, int z);
		une_in_t item;
		item.func = func;
		item.cell_x = COORD_W'(x);
		item.cell_y = COORD_W'(y);
		item.cell_z = COORD_W'(z);
		return item;
	endfunction

	// Mostly interior cells, often next to the previous one so neighbourhoods overlap;
	// the rest are clears and cells anywhere in the index range.
	function automatic une_in_t pick_item();
		une_in_t item;
		int      roll, nx, ny, nz, lo_z, hi_z;
		nx = axis_cells(grid_x);
		ny = axis_cells(grid_y);
		nz = axis_cells(grid_z);
		lo_z = grid_flat ? 0 : 1;
		hi_z = grid_flat ? nz - 1 : nz - 2;
		roll = int'($urandom_range(0, 99));
		item = make_item(FUNC_QUERY, int'($urandom_range(0, 31)), int'($urandom_range(0, 31)),
			int'($urandom_range(0, 31)));
		if (roll < 6) begin
			item.func = FUNC_CLEAR;
		end else if (roll >= 20 && nx >= 3 && ny >= 3 && hi_z >= lo_z) begin
			if (roll < 60) begin
				walk_x = clamp(walk_x + int'($urandom_range(0, 2)) - 1, 1, nx - 2);
				walk_y = clamp(walk_y + int'($urandom_range(0, 2)) - 1, 1, ny - 2);
				walk_z = clamp(walk_z + int'($urandom_range(0, 2)) - 1, lo_z, hi_z);
			end else begin
				walk_x = int'($urandom_range(1, nx - 2));
				walk_y = int'($urandom_range(1, ny - 2));
				walk_z = int'($urandom_range(lo_z, hi_z));
			end
			item = make_item(FUNC_QUERY, walk_x, walk_y, walk_z);
		end
		return item;
	endfunction

	task automatic send_item(input une_in_t item);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		enumerate_unvisited(item);
	endtask

	task automatic query_cell(input int x, input int y, input int z);
		send_item(make_item(FUNC_QUERY, x, y, z));
	endtask

	task automatic send_random(input int count);
		repeat (count) send_item(pick_item());
	endtask

	// Drops valid after the last transaction and waits until every listed result is back.
	task automatic wait_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (awaited_neighbours.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_SIZE_X: grid_x = value;
			REG_SIZE_Y: grid_y = value;
			REG_SIZE_Z: grid_z = value;
			REG_FLAT_MODE: grid_flat = value[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_grid(input int sx, input int sy, input int sz, input bit flat);
		wait_drain();
		write_reg(REG_SIZE_X, SIZE_W'(sx));
		write_reg(REG_SIZE_Y, SIZE_W'(sy));
		write_reg(REG_SIZE_Z, SIZE_W'(sz));
		write_reg(REG_FLAT_MODE, SIZE_W'(flat));
		walk_x = 1;
		walk_y = 1;
		walk_z = 1;
	endtask

	// Register values after reset: a 3x3 flat grid with a single interior cell.
	task automatic test_default_grid();
		query_cell(1, 1, 0);
		query_cell(1, 1, 0);
		query_cell(0, 1, 0);
		query_cell(2, 2, 0);
		query_cell(1, 1, 1);
		query_cell(31, 31, 31);
		send_item(make_item(FUNC_CLEAR, 31, 31, 31));
		query_cell(1, 1, 0);
	endtask

	// Full 26-neighbour stencil, z halo layers, and the same grid in flat mode.
	task automatic test_cube();
		set_grid(5, 5, 5, 1'b0);
		query_cell(2, 2, 2);
		query_cell(2, 2, 0);
		query_cell(2, 2, 4);
		query_cell(2, 2, 3);
		query_cell(1, 3, 1);
		send_item(make_item(FUNC_CLEAR, 0, 0, 0));
		set_grid(5, 5, 5, 1'b1);
		query_cell(2, 2, 0);
	endtask

	// Largest grid, sizes above the axis limit, and sizes too small for any interior cell.
	task automatic test_axis_extremes();
		set_grid(32, 32, 32, 1'b0);
		query_cell(30, 30, 30);
		query_cell(1, 1, 1);
		query_cell(31, 5, 5);
		query_cell(16, 0, 9);
		set_grid(63, 33, 40, 1'b0);
		query_cell(1, 30, 1);
		query_cell(30, 30, 30);
		set_grid(0, 3, 3, 1'b1);
		query_cell(0, 1, 1);
		set_grid(3, 3, 0, 1'b1);
		query_cell(1, 1, 0);
		set_grid(2, 2, 1, 1'b1);
		query_cell(1, 1, 0);
		set_grid(1, 32, 32, 1'b0);
		query_cell(0, 5, 5);
	endtask

	// The receiver stops long enough for the core to stall its input, then the sender
	// waits for every result before going on.
	task automatic test_backpressure();
		set_grid(12, 12, 6, 1'b0);
		hold_request = 1'b1;
		send_random(8);
		wait_drain();
		send_random(6);
	endtask

	task automatic test_random_grids();
		set_grid(8, 8, 1, 1'b1);
		send_random(16);
		set_grid(7, 6, 5, 1'b0);
		send_random(16);
		set_grid(32, 32, 32, 1'b0);
		send_random(16);
		set_grid(20, 9, 32, 1'b1);
		send_random(16);
	endtask

	task automatic test_steady_flow();
		set_grid(6, 6, 3, 1'b1);
		idle_on = 1'b0;
		send_random(18);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_default_grid();
		test_cube();
		test_axis_extremes();
		test_backpressure();
		test_random_grids();
		test_steady_flow();
		wait_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (awaited_neighbours.size() != 0) begin
			$error("%0d results never arrived", awaited_neighbours.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Output ready: random stall bursts, plus one long hold-off when requested.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_request = 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(0, 18)) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		une_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_neighbours.size() == 0) begin
				$error("result transaction with no expectation waiting");
				fail_count++;
			end else begin
				want = awaited_neighbours.pop_front();
				check_field("nb_x", int'(want.nb_x), int'(out_data.nb_x));
				check_field("nb_y", int'(want.nb_y), int'(out_data.nb_y));
				check_field("nb_z", int'(want.nb_z), int'(out_data.nb_z));
				check_field("empty_res", int'(want.empty_res), int'(out_data.empty_res));
				check_field("last", int'(want.last), int'(out_data.last));
			end
		end
	end

	// The clear sweep after reset and each clear command pass no transaction while they run,
	// so the limit is set well above their length.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

endmodule

// ===== files.f =====
+incdir+src
src/une_pkg.sv
src/unvisited_neighbour_enumerator_core.sv
test/tb_unvisited_neighbour_enumerator_core.sv
